// ===== rtl/smao_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smao_pkg: shared types and constants
// Sample type, axis counts and control register map of the six-axis
// moving-average filter with gyroscope offset removal.
// ----------------------------------------------------------------------------
package smao_pkg;

   // sample geometry
   localparam int DATA_W      = 16;
   localparam int AXES        = 6;
   localparam int ACCEL_AXES  = 3;
   localparam int ROW_W       = DATA_W * AXES;

   // control port geometry
   localparam int CSR_ADDR_W  = 4;
   localparam int CSR_DATA_W  = 32;

   typedef logic signed [DATA_W-1:0] sample_type;

   // control register index (byte address / 4)
   typedef enum logic [1:0] {
      REG_GYRO_OFFSET_X = 2'd0,
      REG_GYRO_OFFSET_Y = 2'd1,
      REG_GYRO_OFFSET_Z = 2'd2
   } csr_index_type;

endpackage
`default_nettype wire

// ===== rtl/six_axis_moving_average_offset.sv =====
// result path: stage 1, running sum, divider product, output register
// throughput: one request per cycle while the output is not stalled, set by the
//   per-axis running-sum update that reads oldest and writes newest history rows
// reset: history rows read as zero until first written (one valid bit per
//   row), running sums, write position and gyro offsets clear to zero
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// six_axis_moving_average_offset: six-axis moving-average filter
// Keeps the last WINDOW samples of each axis in a history memory, updates a
// running sum per axis, divides by WINDOW and removes the gyroscope offsets.
// ----------------------------------------------------------------------------
module six_axis_moving_average_offset #(
   parameter int WINDOW = 10
) (
   input  logic                                  clock,
   input  logic                                  reset,

   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  smao_pkg::sample_type                  req_accel_x,
   input  smao_pkg::sample_type                  req_accel_y,
   input  smao_pkg::sample_type                  req_accel_z,
   input  smao_pkg::sample_type                  req_rate_x,
   input  smao_pkg::sample_type                  req_rate_y,
   input  smao_pkg::sample_type                  req_rate_z,

   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output smao_pkg::sample_type                  rsp_mean_accel_x,
   output smao_pkg::sample_type                  rsp_mean_accel_y,
   output smao_pkg::sample_type                  rsp_mean_accel_z,
   output smao_pkg::sample_type                  rsp_mean_rate_x,
   output smao_pkg::sample_type                  rsp_mean_rate_y,
   output smao_pkg::sample_type                  rsp_mean_rate_z,

   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [smao_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [smao_pkg::CSR_DATA_W-1:0]       csr_pwdata,
   output logic [smao_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                  csr_pready
);
   import smao_pkg::*;

   localparam int POS_W = $clog2(WINDOW);
   localparam int SUM_W = DATA_W + $clog2(WINDOW);

   // history memory: one row holds one sample of all six axes
   logic [ROW_W-1:0]       hist_mem [WINDOW];
   logic [WINDOW-1:0]      row_vld_ff;

   logic [POS_W-1:0]       pos_ff;
   logic [POS_W-1:0]       pos_in;

   logic                   adv;
   logic                   accept;
   logic [ROW_W-1:0]       req_row;

   // stage 1: new sample plus oldest row read from memory
   logic                   s1_vld_ff;
   logic [POS_W-1:0]       s1_pos_ff;
   logic                   s1_old_vld_ff;
   logic [ROW_W-1:0]       s1_row_ff;
   logic [ROW_W-1:0]       rd_row_ff;
   logic [ROW_W-1:0]       old_row;

   // stage 2: running sums, stage 3: reciprocal products
   logic signed [SUM_W-1:0] acc_ff [AXES];
   logic signed [SUM_W-1:0] acc_in [AXES];
   logic                    s2_vld_ff;
   logic                    s3_vld_ff;
   sample_type              mean [AXES];

   // output register
   logic                    rsp_vld_ff;
   sample_type              rsp_ff [AXES];
   sample_type              rsp_in [AXES];

   // control registers
   sample_type              gyro_off_ff [ACCEL_AXES];
   logic                    csr_wr;
   csr_index_type           csr_idx;

   // pipeline moves whenever the output register can take a result
   assign adv       = !rsp_vld_ff || !rsp_stall;
   assign accept    = req_valid && adv;
   assign req_stall = !adv;

   assign req_row = {req_rate_z, req_rate_y, req_rate_x,
                     req_accel_z, req_accel_y, req_accel_x};

   // write position wraps at the window length
   always_comb begin
      if (pos_ff == POS_W'(WINDOW - 1)) begin
         pos_in = '0;
      end else begin
         pos_in = pos_ff + POS_W'(1);
      end
   end

   // history memory: read the oldest row on accept, write the new row from stage 1
   // when the pipeline advances; a row is reread only after its write has landed
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_row_ff <= hist_mem[pos_ff];
      end
      if (adv && s1_vld_ff) begin
         hist_mem[s1_pos_ff] <= s1_row_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_vld_ff <= '0;
         pos_ff     <= '0;
      end else begin
         if (accept) begin
            pos_ff <= pos_in;
         end
         if (adv && s1_vld_ff) begin
            row_vld_ff[s1_pos_ff] <= 1'b1;
         end
      end
   end

   // stage 1 payload
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pos_ff     <= pos_ff;
         s1_row_ff     <= req_row;
         s1_old_vld_ff <= row_vld_ff[pos_ff];
      end
   end

   // rows never written count as zero
   assign old_row = s1_old_vld_ff ? rd_row_ff : '0;

   // running sum: add newest, drop oldest
   always_comb begin
      for (int a = 0; a < AXES; a++) begin
         acc_in[a] = acc_ff[a]
                   + SUM_W'(signed'(s1_row_ff[a*DATA_W +: DATA_W]))
                   - SUM_W'(signed'(old_row[a*DATA_W +: DATA_W]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < AXES; a++) begin
            acc_ff[a] <= '0;
         end
      end else if (adv && s1_vld_ff) begin
         for (int a = 0; a < AXES; a++) begin
            acc_ff[a] <= acc_in[a];
         end
      end
   end

   // pipeline valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         s3_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else if (adv) begin
         s1_vld_ff  <= req_valid;
         s2_vld_ff  <= s1_vld_ff;
         s3_vld_ff  <= s2_vld_ff;
         rsp_vld_ff <= s3_vld_ff;
      end
   end

   // one divider lane per axis
   for (genvar g = 0; g < AXES; g++) begin : g_lane
      smao_mean_div #(
         .WINDOW (WINDOW)
      ) u_div (
         .clock  (clock),
         .en     (adv),
         .sum_i  (acc_ff[g]),
         .mean_o (mean[g])
      );
   end

   // gyro offset removal, wraps to 16 bits
   always_comb begin
      for (int a = 0; a < ACCEL_AXES; a++) begin
         rsp_in[a] = mean[a];
      end
      for (int g = 0; g < AXES - ACCEL_AXES; g++) begin
         rsp_in[ACCEL_AXES + g] = mean[ACCEL_AXES + g] - gyro_off_ff[g];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int a = 0; a < AXES; a++) begin
            rsp_ff[a] <= rsp_in[a];
         end
      end
   end

   assign rsp_valid        = rsp_vld_ff;
   assign rsp_mean_accel_x = rsp_ff[0];
   assign rsp_mean_accel_y = rsp_ff[1];
   assign rsp_mean_accel_z = rsp_ff[2];
   assign rsp_mean_rate_x  = rsp_ff[3];
   assign rsp_mean_rate_y  = rsp_ff[4];
   assign rsp_mean_rate_z  = rsp_ff[5];

   // control register write
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = csr_index_type'(csr_paddr[CSR_ADDR_W-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ACCEL_AXES; i++) begin
            gyro_off_ff[i] <= '0;
         end
      end else if (csr_wr) begin
         case (csr_idx)
            REG_GYRO_OFFSET_X: gyro_off_ff[0] <= sample_type'(csr_pwdata[DATA_W-1:0]);
            REG_GYRO_OFFSET_Y: gyro_off_ff[1] <= sample_type'(csr_pwdata[DATA_W-1:0]);
            REG_GYRO_OFFSET_Z: gyro_off_ff[2] <= sample_type'(csr_pwdata[DATA_W-1:0]);
            default: ;
         endcase
      end
   end

   // control register read
   always_comb begin
      case (csr_idx)
         REG_GYRO_OFFSET_X: csr_prdata = CSR_DATA_W'(unsigned'(gyro_off_ff[0]));
         REG_GYRO_OFFSET_Y: csr_prdata = CSR_DATA_W'(unsigned'(gyro_off_ff[1]));
         REG_GYRO_OFFSET_Z: csr_prdata = CSR_DATA_W'(unsigned'(gyro_off_ff[2]));
         default:           csr_prdata = '0;
      endcase
   end

endmodule
`default_nettype wire

// ===== rtl/smao_mean_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smao_mean_div: window sum divided by the window length
// Signed division by a constant, truncated toward zero, done as a
// reciprocal multiply (registered) followed by a one-step correction.
// ----------------------------------------------------------------------------
module smao_mean_div #(
   parameter int WINDOW = 10,
   localparam int SUM_W = smao_pkg::DATA_W + $clog2(WINDOW)
) (
   input  logic                    clock,
   input  logic                    en,
   input  logic signed [SUM_W-1:0] sum_i,
   output smao_pkg::sample_type    mean_o
);
   import smao_pkg::*;

   localparam int SHIFT  = SUM_W;
   localparam int PROD_W = SHIFT + DATA_W;
   localparam logic [SUM_W-1:0] RECIP = SUM_W'((64'd1 << SHIFT) / WINDOW);

   logic [SUM_W-1:0]  sum_u;
   logic              neg;
   logic [SUM_W-1:0]  mag;
   logic [PROD_W-1:0] prod_in;

   logic [PROD_W-1:0] prod_ff;
   logic [SUM_W-1:0]  mag_ff;
   logic              neg_ff;

   logic [DATA_W-1:0] q_est;
   logic [SUM_W-1:0]  q_times_w;
   logic [SUM_W-1:0]  rem;
   logic [DATA_W-1:0] q_fix;

   // magnitude and reciprocal product
   always_comb begin
      sum_u   = sum_i;
      neg     = sum_i[SUM_W-1];
      mag     = neg ? (~sum_u + SUM_W'(1)) : sum_u;
      prod_in = PROD_W'((2*SUM_W)'(mag) * (2*SUM_W)'(RECIP));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
         mag_ff  <= mag;
         neg_ff  <= neg;
      end
   end

   // quotient estimate is at most one low; fix it and restore the sign
   always_comb begin
      q_est     = prod_ff[SHIFT +: DATA_W];
      q_times_w = SUM_W'(q_est) * SUM_W'(WINDOW);
      rem       = mag_ff - q_times_w;
      q_fix     = (rem >= SUM_W'(WINDOW)) ? (q_est + DATA_W'(1)) : q_est;
      mean_o    = neg_ff ? sample_type'(~q_fix + DATA_W'(1)) : sample_type'(q_fix);
   end

endmodule
`default_nettype wire

// ===== sim/tb_six_axis_moving_average_offset.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_six_axis_moving_average_offset: self-checking bench for the six-axis filter
// Streams six-axis samples through the filter, predicts each ten-sample window
// mean and gyro offset removal, and checks every result field. Offsets are
// reprogrammed between traffic phases, with random idles and stalls on both
// channels and one long receiver hold that backs the pipeline up.
// ----------------------------------------------------------------------------
module tb_six_axis_moving_average_offset;
   import smao_pkg::*;

   localparam int WINDOW      = 10;
   localparam int HOLD_CYCLES = 80;
   localparam int DRAIN_LIMIT = 20000;

   typedef logic [AXES-1:0][DATA_W-1:0] axis_set_type;
   typedef enum int {BURST_NOISE, BURST_HELD, BURST_SMALL} burst_kind_type;

   logic clock;
   logic reset = 1'b1;

   logic         req_valid = 1'b0;
   logic         req_stall;
   axis_set_type req_item  = '0;

   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   sample_type mean_ax, mean_ay, mean_az, mean_rx, mean_ry, mean_rz;

   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // filter state mirrored by the bench
   logic signed [DATA_W-1:0] history [AXES][WINDOW];
   int unsigned              oldest_slot = 0;
   sample_type               rate_bias [3];

   axis_set_type sample_queue [$];
   axis_set_type mean_queue [$];
   axis_set_type got_mean, want_mean;

   bit    no_idle = 1'b0;
   int    hold_asked = 0, hold_done = 0, hold_left = 0;
   int    mismatch_count = 0, samples_taken = 0, means_checked = 0;
   string field_name [AXES] = '{"mean_accel_x", "mean_accel_y", "mean_accel_z",
                                "mean_rate_x", "mean_rate_y", "mean_rate_z"};

   six_axis_moving_average_offset #(.WINDOW(WINDOW)) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_accel_x      (req_item[0]),
      .req_accel_y      (req_item[1]),
      .req_accel_z      (req_item[2]),
      .req_rate_x       (req_item[3]),
      .req_rate_y       (req_item[4]),
      .req_rate_z       (req_item[5]),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_mean_accel_x (mean_ax),
      .rsp_mean_accel_y (mean_ay),
      .rsp_mean_accel_z (mean_az),
      .rsp_mean_rate_x  (mean_rx),
      .rsp_mean_rate_y  (mean_ry),
      .rsp_mean_rate_z  (mean_rz),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      foreach (history[a, k]) history[a][k] = '0;
      foreach (rate_bias[i]) rate_bias[i] = '0;
   end

   task automatic note_mismatch(string what, int got, int want);
      mismatch_count++;
      $display("mismatch at %0t ns: %s got %0d want %0d", $time, what, got, want);
   endtask

   // push one sample into the window and return the six means it yields
   function automatic axis_set_type window_mean(axis_set_type sample);
      axis_set_type means;
      int           sum;
      int           avg;
      for (int a = 0; a < AXES; a++)
         history[a][oldest_slot] = sample[a];
      oldest_slot = (oldest_slot + 1) % WINDOW;
      for (int a = 0; a < AXES; a++) begin
         sum = 0;
         for (int k = 0; k < WINDOW; k++)
            sum += history[a][k];
         // int division truncates toward zero
         avg = sum / WINDOW;
         if (a >= ACCEL_AXES)
            means[a] = avg[DATA_W-1:0] - rate_bias[a-ACCEL_AXES];
         else
            means[a] = avg[DATA_W-1:0];
      end
      return means;
   endfunction

   // request driver: offers queued samples, predicts on each accepted request
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            mean_queue.push_back(window_mean(req_item));
            samples_taken++;
         end
         if (!req_valid || !req_stall) begin
            if (sample_queue.size() != 0 && (no_idle || $urandom_range(99) >= 26)) begin
               req_item  <= sample_queue.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor: checks each accepted result and drives the stall
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got_mean = {mean_rz, mean_ry, mean_rx, mean_az, mean_ay, mean_ax};
            if (mean_queue.size() == 0) begin
               note_mismatch("result with no request pending", 0, 0);
            end else begin
               want_mean = mean_queue.pop_front();
               for (int a = 0; a < AXES; a++)
                  if (got_mean[a] !== want_mean[a])
                     note_mismatch(field_name[a], $signed(got_mean[a]),
                                   $signed(want_mean[a]));
               means_checked++;
            end
         end
         // long hold-off when asked, else random stalls
         if (hold_left != 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (hold_done != hold_asked) begin
            hold_done++;
            hold_left = HOLD_CYCLES - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !no_idle && ($urandom_range(99) < 26);
         end
      end
   end

   // write one offset register, then read it back
   task automatic set_rate_bias(csr_index_type idx, sample_type value);
      logic [DATA_W-1:0] readback;
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'(4 * idx);
      csr_pwdata  <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rate_bias[idx] = value;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      readback = csr_prdata[DATA_W-1:0];
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (readback !== value)
         note_mismatch("offset register readback", $signed(readback), value);
   endtask

   // random samples in bursts: noise, held corner values, small signed values
   task automatic queue_random(int count);
      axis_set_type   sample;
      axis_set_type   held;
      burst_kind_type kind;
      int             run;
      int             roll;
      while (count > 0) begin
         roll = $urandom_range(9);
         kind = (roll < 6) ? BURST_NOISE : (roll < 8) ? BURST_HELD : BURST_SMALL;
         run  = $urandom_range(14, 1);
         for (int a = 0; a < AXES; a++) begin
            case ($urandom_range(4))
               0:       held[a] = 16'h7FFF;
               1:       held[a] = 16'h8000;
               2:       held[a] = 16'h0000;
               3:       held[a] = 16'hFFFF;
               default: held[a] = 16'h0001;
            endcase
         end
         for (int n = 0; n < run && count > 0; n++) begin
            for (int a = 0; a < AXES; a++) begin
               case (kind)
                  BURST_NOISE: sample[a] = 16'($urandom);
                  BURST_HELD:  sample[a] = held[a];
                  default:     sample[a] = 16'($urandom_range(40)) - 16'd20;
               endcase
            end
            sample_queue.push_back(sample);
            count--;
         end
      end
   endtask

   // wait until every queued request is sent and every result has returned;
   // checked mid-cycle so the driver's updates at the edge have settled
   task automatic drain();
      int spins;
      spins = 0;
      @(negedge clock);
      while ((sample_queue.size() != 0 || req_valid || mean_queue.size() != 0)
             && spins < DRAIN_LIMIT) begin
         @(negedge clock);
         spins++;
      end
      repeat (8) @(posedge clock);
   endtask

   // stimulus
   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // early outputs with a zero-filled window, negative truncation toward zero
      sample_queue.push_back({6{16'hFFF7}});
      sample_queue.push_back({6{16'h0013}});
      // full windows at the extremes: accel high with rate low, then swapped
      repeat (WINDOW) sample_queue.push_back({{3{16'h8000}}, {3{16'h7FFF}}});
      repeat (WINDOW) sample_queue.push_back({{3{16'h7FFF}}, {3{16'h8000}}});
      queue_random(200);
      drain();

      // extreme offsets so the gyro difference wraps
      set_rate_bias(REG_GYRO_OFFSET_X, 16'sh7FFF);
      set_rate_bias(REG_GYRO_OFFSET_Y, 16'sh8000);
      set_rate_bias(REG_GYRO_OFFSET_Z, 16'sh0001);
      queue_random(250);
      drain();

      // back-to-back traffic with a long receiver hold
      set_rate_bias(REG_GYRO_OFFSET_X, 16'sh8000);
      set_rate_bias(REG_GYRO_OFFSET_Y, 16'sh7FFF);
      set_rate_bias(REG_GYRO_OFFSET_Z, 16'shFFFF);
      no_idle = 1'b1;
      queue_random(300);
      hold_asked++;
      drain();
      no_idle = 1'b0;

      // random offsets
      set_rate_bias(REG_GYRO_OFFSET_X, sample_type'($urandom));
      set_rate_bias(REG_GYRO_OFFSET_Y, sample_type'($urandom));
      set_rate_bias(REG_GYRO_OFFSET_Z, sample_type'($urandom));
      queue_random(380);
      drain();

      if (mean_queue.size() != 0)
         note_mismatch("results never returned", mean_queue.size(), 0);
      $display("%0d samples filtered, %0d results checked over four offset settings",
               samples_taken, means_checked);
      $display("included saturated windows, wrapping gyro offsets and an %0d-cycle hold",
               HOLD_CYCLES);
      if (mismatch_count == 0) begin
         $display("[six_axis_moving_average_offset] OK");
      end else begin
         $display("[six_axis_moving_average_offset] ERROR");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("[six_axis_moving_average_offset] ERROR");
      $finish;
   end

endmodule

// ===== six_axis_moving_average_offset.f =====
rtl/smao_pkg.sv
rtl/smao_mean_div.sv
rtl/six_axis_moving_average_offset.sv
sim/tb_six_axis_moving_average_offset.sv
